// ----- hdl/ecpg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ecpg_pkg
// shared types, constants and tables of the circle point generator
// ----------------------------------------------------------------------------
package ecpg_pkg;

    localparam int ANGLE_W       = 16;
    localparam int IDX_W         = 6;
    localparam int CNT_W         = 7;
    localparam int Q_W           = 16;
    localparam int MAX_POINTS    = 64;
    localparam int CORDIC_STAGES = 16;
    localparam int CW            = 33;   // cordic x, y and z word

    localparam logic [CNT_W-1:0]       RESET_COUNT = CNT_W'(8);
    localparam logic [CNT_W-1:0]       MAX_COUNT   = CNT_W'(MAX_POINTS);
    localparam logic signed [CW-1:0]   CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [CW:0]     ROUND_HALF  = 34'sd32768;
    localparam logic signed [CW:0]     Q14_POS     = 34'sd16384;
    localparam logic signed [CW:0]     Q14_NEG     = -34'sd16384;

    typedef logic [ANGLE_W-1:0] angle_t;
    typedef logic signed [Q_W-1:0] q14_t;
    typedef logic signed [CW-1:0] cword_t;

    // sideband that travels with each point through the pipeline
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        angle_t           angle;
        logic             last;
    } tag_t;

    // sequencer status seen by the top level
    typedef struct packed {
        logic             busy;
        logic             last;
        logic [IDX_W-1:0] idx;
    } seq_stat_t;

    // atan(2^-i) in 2^32 units per turn
    function automatic cword_t atan_turn(input int unsigned i);
        cword_t r;
        case (i)
            0:  r = 33'sd536870912;
            1:  r = 33'sd316933406;
            2:  r = 33'sd167458907;
            3:  r = 33'sd85004756;
            4:  r = 33'sd42667331;
            5:  r = 33'sd21354465;
            6:  r = 33'sd10679838;
            7:  r = 33'sd5340245;
            8:  r = 33'sd2670163;
            9:  r = 33'sd1335087;
            10: r = 33'sd667544;
            11: r = 33'sd333772;
            12: r = 33'sd166886;
            13: r = 33'sd83443;
            14: r = 33'sd41722;
            15: r = 33'sd20861;
            16: r = 33'sd10430;
            17: r = 33'sd5215;
            18: r = 33'sd2608;
            19: r = 33'sd1304;
            20: r = 33'sd652;
            21: r = 33'sd326;
            22: r = 33'sd163;
            23: r = 33'sd81;
            24: r = 33'sd41;
            25: r = 33'sd20;
            26: r = 33'sd10;
            27: r = 33'sd5;
            28: r = 33'sd3;
            29: r = 33'sd1;
            30: r = 33'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    // zero counts as one point, anything above the maximum saturates
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] raw);
        logic [CNT_W-1:0] r;
        if (raw == '0)
            r = CNT_W'(1);
        else if (raw > MAX_COUNT)
            r = MAX_COUNT;
        else
            r = raw;
        return r;
    endfunction

    // full turn divided by the count, truncated; two points step a quarter turn
    function automatic angle_t step_of(input logic [CNT_W-1:0] n);
        angle_t r;
        unique case (n)
            7'd2:  r = 16'd16384;
            7'd3:  r = 16'd21845;
            7'd4:  r = 16'd16384;
            7'd5:  r = 16'd13107;
            7'd6:  r = 16'd10922;
            7'd7:  r = 16'd9362;
            7'd8:  r = 16'd8192;
            7'd9:  r = 16'd7281;
            7'd10: r = 16'd6553;
            7'd11: r = 16'd5957;
            7'd12: r = 16'd5461;
            7'd13: r = 16'd5041;
            7'd14: r = 16'd4681;
            7'd15: r = 16'd4369;
            7'd16: r = 16'd4096;
            7'd17: r = 16'd3855;
            7'd18: r = 16'd3640;
            7'd19: r = 16'd3449;
            7'd20: r = 16'd3276;
            7'd21: r = 16'd3120;
            7'd22: r = 16'd2978;
            7'd23: r = 16'd2849;
            7'd24: r = 16'd2730;
            7'd25: r = 16'd2621;
            7'd26: r = 16'd2520;
            7'd27: r = 16'd2427;
            7'd28: r = 16'd2340;
            7'd29: r = 16'd2259;
            7'd30: r = 16'd2184;
            7'd31: r = 16'd2114;
            7'd32: r = 16'd2048;
            7'd33: r = 16'd1985;
            7'd34: r = 16'd1927;
            7'd35: r = 16'd1872;
            7'd36: r = 16'd1820;
            7'd37: r = 16'd1771;
            7'd38: r = 16'd1724;
            7'd39: r = 16'd1680;
            7'd40: r = 16'd1638;
            7'd41: r = 16'd1598;
            7'd42: r = 16'd1560;
            7'd43: r = 16'd1524;
            7'd44: r = 16'd1489;
            7'd45: r = 16'd1456;
            7'd46: r = 16'd1424;
            7'd47: r = 16'd1394;
            7'd48: r = 16'd1365;
            7'd49: r = 16'd1337;
            7'd50: r = 16'd1310;
            7'd51: r = 16'd1285;
            7'd52: r = 16'd1260;
            7'd53: r = 16'd1236;
            7'd54: r = 16'd1213;
            7'd55: r = 16'd1191;
            7'd56: r = 16'd1170;
            7'd57: r = 16'd1149;
            7'd58: r = 16'd1129;
            7'd59: r = 16'd1110;
            7'd60: r = 16'd1092;
            7'd61: r = 16'd1074;
            7'd62: r = 16'd1057;
            7'd63: r = 16'd1040;
            7'd64: r = 16'd1024;
            default: r = '0;   // one point: a full turn wraps to zero
        endcase
        return r;
    endfunction

    // round to q1.14 and saturate
    function automatic q14_t to_q14(input cword_t v);
        logic signed [CW:0] s;
        logic signed [CW:0] r;
        q14_t               q;
        s = {v[CW-1], v} + ROUND_HALF;
        r = s >>> 16;
        if (r > Q14_POS)
            q = Q14_POS[Q_W-1:0];
        else if (r < Q14_NEG)
            q = Q14_NEG[Q_W-1:0];
        else
            q = r[Q_W-1:0];
        return q;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/ecpg_sequencer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ecpg_sequencer
// point count register and per-run angle stepping, one point per cycle while adv is high
// ----------------------------------------------------------------------------
module ecpg_sequencer
    import ecpg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    input  wire logic [CNT_W-1:0]  cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire angle_t            in_angle,
    input  wire logic              adv,
    output logic                   issue_valid,
    output tag_t                   issue_tag,
    output seq_stat_t              stat,
    output logic [CNT_W-1:0]       count
);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    angle_t           step_reg;
    angle_t           step_next;
    logic             busy_reg;
    logic [IDX_W-1:0] idx_reg;
    angle_t           ang_reg;
    logic             is_last;

    assign cnt_next  = clamp_count(cfg_data);
    assign step_next = step_of(cnt_next);
    assign is_last   = ({1'b0, idx_reg} == (cnt_reg - CNT_W'(1)));
    // a new run may load in the cycle the last point of the old one issues
    assign in_ready  = !busy_reg || (adv && is_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= RESET_COUNT;
            step_reg <= step_of(RESET_COUNT);
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            ang_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cnt_reg  <= cnt_next;
                step_reg <= step_next;
            end
            if (busy_reg && adv)
            begin
                if (is_last)
                    busy_reg <= 1'b0;
                else
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    ang_reg <= ang_reg + step_reg;
                end
            end
            if (in_valid && in_ready)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
                ang_reg  <= in_angle;
            end
        end
    end

    assign issue_valid    = busy_reg;
    assign issue_tag.idx  = idx_reg;
    assign issue_tag.angle = ang_reg;
    assign issue_tag.last = is_last;
    assign stat.busy      = busy_reg;
    assign stat.last      = is_last;
    assign stat.idx       = idx_reg;
    assign count          = cnt_reg;

endmodule
`default_nettype wire

// ----- hdl/ecpg_cordic.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ecpg_cordic
// pipelined rotation-mode cordic with rounding and quadrant mapping
// ----------------------------------------------------------------------------
module ecpg_cordic
    import ecpg_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   adv,
    input  wire logic   in_valid,
    input  wire tag_t   in_tag,
    output logic        out_valid,
    output tag_t        out_tag,
    output q14_t        out_cos,
    output q14_t        out_sin
);

    localparam int NS = CORDIC_STAGES;

    // stage 0 is the setup register, stage k+1 follows rotation k
    logic [NS:0] rv_reg;
    cword_t      x_reg [0:NS];
    cword_t      y_reg [0:NS];
    cword_t      z_reg [0:NS];
    logic [1:0]  q_reg [0:NS];
    tag_t        t_reg [0:NS];

    logic        rnd_v_reg;
    q14_t        rc_reg;
    q14_t        rs_reg;
    logic [1:0]  rq_reg;
    tag_t        rt_reg;

    logic        o_v_reg;
    q14_t        oc_reg;
    q14_t        os_reg;
    tag_t        ot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg    <= '0;
            rnd_v_reg <= 1'b0;
            o_v_reg   <= 1'b0;
        end
        else if (adv)
        begin
            rv_reg    <= {rv_reg[NS-1:0], in_valid};
            rnd_v_reg <= rv_reg[NS];
            o_v_reg   <= rnd_v_reg;
        end
    end

    // setup: quadrant from the top bits, residual widened to 2^32 per turn
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0] <= CORDIC_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= {3'b000, in_tag.angle[ANGLE_W-3:0], 16'b0};
            q_reg[0] <= in_tag.angle[ANGLE_W-1:ANGLE_W-2];
            t_reg[0] <= in_tag;
        end
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_rot
        cword_t dx;
        cword_t dy;
        cword_t at;
        assign dx = y_reg[k] >>> k;
        assign dy = x_reg[k] >>> k;
        assign at = atan_turn(k);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!z_reg[k][CW-1])
                begin
                    x_reg[k+1] <= x_reg[k] - dx;
                    y_reg[k+1] <= y_reg[k] + dy;
                    z_reg[k+1] <= z_reg[k] - at;
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k] + dx;
                    y_reg[k+1] <= y_reg[k] - dy;
                    z_reg[k+1] <= z_reg[k] + at;
                end
                q_reg[k+1] <= q_reg[k];
                t_reg[k+1] <= t_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rc_reg <= to_q14(x_reg[NS]);
            rs_reg <= to_q14(y_reg[NS]);
            rq_reg <= q_reg[NS];
            rt_reg <= t_reg[NS];
            ot_reg <= rt_reg;
            case (rq_reg)
                2'd0:
                begin
                    oc_reg <= rc_reg;
                    os_reg <= rs_reg;
                end
                2'd1:
                begin
                    oc_reg <= -rs_reg;
                    os_reg <= rc_reg;
                end
                2'd2:
                begin
                    oc_reg <= -rc_reg;
                    os_reg <= -rs_reg;
                end
                default:
                begin
                    oc_reg <= rs_reg;
                    os_reg <= -rc_reg;
                end
            endcase
        end
    end

    assign out_valid = o_v_reg;
    assign out_tag   = ot_reg;
    assign out_cos   = oc_reg;
    assign out_sin   = os_reg;

endmodule
`default_nettype wire

// ----- hdl/even_circle_point_generator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// even_circle_point_generator
// evenly spaced points on the unit circle with cosine and sine
// ----------------------------------------------------------------------------
// each start angle taken on the s_axis channel produces point_count results
// on m_axis: point i has angle start + i*step (16-bit fraction of a turn,
// wrapping), its q1.14 cosine and sine, and tlast on the final point
// - step is a full turn over point_count, truncated; two points step a
//   quarter turn; count 0 acts as 1, counts above 64 act as 64
// - point_count is written on the cfg channel (always ready); the user is to
//   write it only while no run is in flight (not enforced); reset sets it to 8
// - the sequencer issues one point per cycle while m_axis does not stall, so a
//   start angle occupies the input until its point_count points have issued;
//   the next one is taken in the cycle its last point issues
// - a start angle passes the issue register, setup, 16 cordic stages, rounding
//   and the output register before its first result is valid
// - a stalled m_axis freezes the whole pipeline; nothing is dropped
// - reset clears the run and all valid bits; the output goes idle
// ----------------------------------------------------------------------------
module even_circle_point_generator
    import ecpg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // config write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data,       // point_count
    // start angles
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // start_angle
    // points
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // point_index, point_angle, cosine, sine
    output logic             m_axis_tlast    // last_point
);

    logic             adv;
    logic             issue_valid;
    tag_t             issue_tag;
    seq_stat_t        stat;
    logic [CNT_W-1:0] count;
    logic             pipe_valid;
    tag_t             pipe_tag;
    q14_t             pipe_cos;
    q14_t             pipe_sin;

    // the whole pipeline moves when the output register is empty or drained
    assign adv       = !pipe_valid || m_axis_tready;
    assign cfg_ready = 1'b1;

    ecpg_sequencer u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_angle    (s_axis_tdata),
        .adv         (adv),
        .issue_valid (issue_valid),
        .issue_tag   (issue_tag),
        .stat        (stat),
        .count       (count)
    );

    ecpg_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (issue_valid),
        .in_tag    (issue_tag),
        .out_valid (pipe_valid),
        .out_tag   (pipe_tag),
        .out_cos   (pipe_cos),
        .out_sin   (pipe_sin)
    );

    // pack fields from the low bit up, pad to whole bytes
    assign m_axis_tvalid = pipe_valid;
    assign m_axis_tdata  = {2'b00, pipe_sin, pipe_cos, pipe_tag.angle, pipe_tag.idx};
    assign m_axis_tlast  = pipe_tag.last;

    // the final point of a run carries index count-1
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> {1'b0, m_axis_tdata[5:0]} == count - 7'd1)
        else $error("last point index does not match point count");

    // an earlier point of a run stays below count-1
    a_mid_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> {1'b0, m_axis_tdata[5:0]} < count - 7'd1)
        else $error("non-final point index out of range");

    // an issued point that is not the last is followed by the next index
    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy && adv && !stat.last |=>
            stat.busy && stat.idx == $past(stat.idx) + 6'd1)
        else $error("sequencer skipped or repeated a point");

endmodule
`default_nettype wire

// ----- tb/sv/tb_even_circle_point_generator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_even_circle_point_generator
// self-checking bench for the evenly spaced circle point generator
// ----------------------------------------------------------------------------
// start angles are queued by the stimulus process and handed to the block by
// a clocked driver; each accepted transfer is turned into its run of expected
// points (angle, q1.14 cosine and sine from a bit-exact cordic, index, last
// mark) by a predictor with its own copy of point_count
// a clocked monitor takes every point transfer and compares it field by field
// with the oldest expected point
// point_count is rewritten only when the block has drained: the reset value
// first, then the edge counts, then random counts with random start angles
// both sides insert random gaps; some phases run without any gaps at all
// ----------------------------------------------------------------------------
module tb_even_circle_point_generator;
    import ecpg_pkg::*;

    // one point as it travels on m_axis
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        angle_t           angle;
        q14_t             cos_q;
        q14_t             sin_q;
        logic             last;
    } point_t;

    localparam longint GAIN_Q30      = 64'sd652032874;
    localparam longint Q14_MAX       = 64'sd16384;
    localparam int     RANDOM_ITEMS  = 180;
    localparam int     SETTLE_CYCLES = 40;          // longer than the pipeline from start angle to output
    localparam int     TIMEOUT_NS    = 60_000_000;  // far beyond the slowest run

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CNT_W-1:0]     cfg_data      = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [ANGLE_W-1:0]   s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [55:0]          m_axis_tdata;   // point_index, point_angle, cosine, sine
    logic                 m_axis_tlast;   // last_point

    // bench-side copy of the point_count register
    logic [CNT_W-1:0]     point_count_copy = RESET_COUNT;

    angle_t               pending_starts[$];
    point_t               expected_points[$];
    int unsigned          mismatch_count = 0;
    bit                   quiet_phase    = 1'b0;   // no gaps on either side
    int unsigned          start_gap      = 0;
    int unsigned          sink_stall     = 0;

    even_circle_point_generator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // atan(2^-i) in 2^32 units per turn, rounded
    function automatic longint atan_step(input int unsigned i);
        longint r;
        case (i)
            0:  r = 536870912;
            1:  r = 316933406;
            2:  r = 167458907;
            3:  r = 85004756;
            4:  r = 42667331;
            5:  r = 21354465;
            6:  r = 10679838;
            7:  r = 5340245;
            8:  r = 2670163;
            9:  r = 1335087;
            10: r = 667544;
            11: r = 333772;
            12: r = 166886;
            13: r = 83443;
            14: r = 41722;
            15: r = 20861;
            default: r = 0;
        endcase
        return r;
    endfunction

    // q30 down to q1.14 with round half up, clipped to +-1.0
    function automatic longint round_q14(input longint v);
        longint r;
        r = (v + 64'sd32768) >>> 16;
        if (r > Q14_MAX)
            r = Q14_MAX;
        else if (r < -Q14_MAX)
            r = -Q14_MAX;
        return r;
    endfunction

    // cosine and sine of one point angle
    function automatic point_t circle_point(input logic [IDX_W-1:0] idx,
                                            input angle_t ang, input logic last);
        point_t      p;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        longint      c;
        longint      s;
        int unsigned i;
        // top two bits pick the quadrant, the rest is the residual angle in
        // 2^32 units per turn
        x = GAIN_Q30;
        y = 0;
        z = longint'({ang[ANGLE_W-3:0], 16'h0000});
        for (i = 0; i < CORDIC_STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_step(i);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_step(i);
            end
        end
        c = round_q14(x);
        s = round_q14(y);
        p.idx   = idx;
        p.angle = ang;
        p.last  = last;
        case (ang[ANGLE_W-1:ANGLE_W-2])
            2'd0:
            begin
                p.cos_q = q14_t'(c);
                p.sin_q = q14_t'(s);
            end
            2'd1:
            begin
                p.cos_q = q14_t'(-s);
                p.sin_q = q14_t'(c);
            end
            2'd2:
            begin
                p.cos_q = q14_t'(-c);
                p.sin_q = q14_t'(-s);
            end
            default:
            begin
                p.cos_q = q14_t'(s);
                p.sin_q = q14_t'(-c);
            end
        endcase
        return p;
    endfunction

    // whole run of points caused by one start angle
    task automatic predict_run(input angle_t start);
        int unsigned n;
        int unsigned i;
        angle_t      step;
        angle_t      ang;
        n = point_count_copy;
        // zero acts as one point, counts past the maximum saturate
        if (n == 0)
            n = 1;
        if (n > MAX_POINTS)
            n = MAX_POINTS;
        // two points step a quarter turn; one point steps a full turn, i.e. zero
        if (n == 2)
            step = angle_t'(32'd1 << (ANGLE_W - 2));
        else
            step = angle_t'((32'd1 << ANGLE_W) / n);
        ang = start;
        for (i = 0; i < n; i++)
        begin
            expected_points.push_back(circle_point(IDX_W'(i), ang, i == n - 1));
            ang = ang + step;
        end
    endtask

    // ------------------------------------------------------------------------
    // gaps: mostly none, some short, a few long
    // ------------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // ------------------------------------------------------------------------
    // driver: start angles from the pending queue onto s_axis
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            start_gap = 0;
        end
        else
        begin
            // a start angle transfer fixes its whole run of points
            if (s_axis_tvalid && s_axis_tready)
                predict_run(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (start_gap > 0)
                begin
                    start_gap = start_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_starts.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_starts.pop_front();
                    start_gap = pick_gap();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: point transfers against the expected points, with random stalls
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        point_t got;
        point_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_stall = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                // tdata from bit 0 up: index, angle, cosine, sine
                got.idx   = m_axis_tdata[5:0];
                got.angle = m_axis_tdata[21:6];
                got.cos_q = m_axis_tdata[37:22];
                got.sin_q = m_axis_tdata[53:38];
                got.last  = m_axis_tlast;
                if (expected_points.size() == 0)
                begin
                    $error("unexpected point: index %0d angle %0d", got.idx, got.angle);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (got.idx !== want.idx)
                    begin
                        $error("point_index: expected %0d, got %0d", want.idx, got.idx);
                        mismatch_count++;
                    end
                    if (got.angle !== want.angle)
                    begin
                        $error("point_angle: expected %0d, got %0d", want.angle, got.angle);
                        mismatch_count++;
                    end
                    if (got.cos_q !== want.cos_q)
                    begin
                        $error("cosine: expected %0d, got %0d", want.cos_q, got.cos_q);
                        mismatch_count++;
                    end
                    if (got.sin_q !== want.sin_q)
                    begin
                        $error("sine: expected %0d, got %0d", want.sin_q, got.sin_q);
                        mismatch_count++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last_point: expected %0d, got %0d", want.last, got.last);
                        mismatch_count++;
                    end
                end
            end
            if (sink_stall > 0)
            begin
                sink_stall = sink_stall - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                sink_stall = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    // point_count write, only issued while the block is drained
    task automatic write_point_count(input logic [CNT_W-1:0] value);
        @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        point_count_copy = value;
    endtask

    // all start angles taken and every expected point seen, then let the
    // pipeline settle so that stray points would still be caught; checked
    // between edges so that the driver and monitor updates have landed
    task automatic wait_drained();
        while (pending_starts.size() != 0 || s_axis_tvalid || expected_points.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random angles, a share of them right at the quadrant boundaries
    function automatic angle_t random_angle();
        angle_t a;
        if ($urandom_range(0, 9) < 7)
            a = angle_t'($urandom_range(0, 65535));
        else
            a = angle_t'({$urandom_range(0, 3), 14'd0} + $urandom_range(0, 2) - 1);
        return a;
    endfunction

    initial
    begin
        int unsigned sent;
        int unsigned batch;
        int unsigned pick;
        int unsigned count;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset count of 8: axis angles, both extremes, near-boundary values
        pending_starts.push_back(16'h0000);
        pending_starts.push_back(16'hFFFF);
        pending_starts.push_back(16'h4000);
        pending_starts.push_back(16'h8000);
        pending_starts.push_back(16'hC000);
        pending_starts.push_back(16'h3FFF);
        pending_starts.push_back(16'h2000);
        pending_starts.push_back(16'h0001);
        pending_starts.push_back(16'h5555);
        pending_starts.push_back(16'hAAAA);
        wait_drained();

        // single point: step wraps to zero, the one point carries last
        write_point_count(7'd1);
        pending_starts.push_back(16'h0000);
        pending_starts.push_back(16'hFFFF);
        wait_drained();

        // two points step a quarter turn instead of a half
        write_point_count(7'd2);
        pending_starts.push_back(16'h1234);
        pending_starts.push_back(16'hE000);
        wait_drained();

        // largest run
        write_point_count(7'd64);
        pending_starts.push_back(16'h8001);
        wait_drained();

        // zero count acts as one point
        write_point_count(7'd0);
        pending_starts.push_back(16'h7FFF);
        wait_drained();

        // counts above the maximum saturate
        write_point_count(7'd127);
        pending_starts.push_back(16'hC000);
        wait_drained();

        write_point_count(7'd65);
        pending_starts.push_back(16'h3FFF);
        wait_drained();

        // odd count, truncated step
        write_point_count(7'd3);
        pending_starts.push_back(16'hBFFF);
        pending_starts.push_back(16'h0001);
        wait_drained();

        // random phases, mostly short runs
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                count = $urandom_range(1, 12);
            else if (pick < 90)
                count = $urandom_range(13, 64);
            else
                count = $urandom_range(0, 127);
            quiet_phase = ($urandom_range(0, 3) == 0);
            write_point_count(CNT_W'(count));
            batch = $urandom_range(4, 16);
            repeat (batch) pending_starts.push_back(random_angle());
            sent += batch;
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
